FILE: rtl/pda_pkg.sv
// ----------------------------------------------------------------------------
// pda_pkg: shared types and codes of the pushdown automaton recognizer
// Transition record, action and status codes, memory command groups.
// ----------------------------------------------------------------------------
package pda_pkg;

  localparam int unsigned STATE_W  = 4;
  localparam int unsigned SYM_W    = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 7;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned MAX_LISTS = 16;

  // Push or pop symbol that stands for no stack operation
  localparam logic [SYM_W-1:0] NONE_SYMBOL = 8'd126;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_FEED   = 2'd1,
    ACT_FINISH = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOMATCH  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_REFUSED  = 3'd4,
    ST_FULL     = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  typedef struct packed {
    logic [STATE_W-1:0] target;
    logic [SYM_W-1:0]   rd;
    logic [SYM_W-1:0]   push;
    logic [SYM_W-1:0]   pop;
  } trans_t;

  typedef struct packed {
    logic add;
    logic clear;
    logic rd_en;
  } tstore_cmd_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } stack_cmd_t;

endpackage

FILE: rtl/pda_tstore.sv
// ----------------------------------------------------------------------------
// pda_tstore: transition store
// Per-state transition lists in one synchronous memory, plus list counts.
// ----------------------------------------------------------------------------
module pda_tstore #(
  parameter int unsigned NUM_LISTS       = 16,
  parameter int unsigned MAX_TRANSITIONS = 8,
  localparam int unsigned LW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
  localparam int unsigned TW = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1,
  localparam int unsigned CW = $clog2(MAX_TRANSITIONS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pda_pkg::tstore_cmd_t cmd_i,
  input  logic [LW-1:0]       wr_list_i,
  input  pda_pkg::trans_t     wr_data_i,
  input  logic [LW-1:0]       rd_list_i,
  input  logic [TW-1:0]       rd_idx_i,
  output pda_pkg::trans_t     rd_data_o,
  input  logic [LW-1:0]       cnt_list_i,
  output logic [CW-1:0]       cnt_o
);
  import pda_pkg::*;

  localparam int unsigned DEPTH = NUM_LISTS * (2 ** TW);
  localparam int unsigned AW    = LW + TW;

  logic [CW-1:0] cnt_q [NUM_LISTS];
  trans_t        mem_q [DEPTH];
  trans_t        rd_data_q;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  // Append at the tail of the list, read entry by list and position
  assign waddr     = {wr_list_i, cnt_q[wr_list_i][TW-1:0]};
  assign raddr     = {rd_list_i, rd_idx_i};
  assign cnt_o     = cnt_q[cnt_list_i];
  assign rd_data_o = rd_data_q;

  // List counts: clear all at once, advance on append
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (cmd_i.add) begin
      cnt_q[wr_list_i] <= cnt_q[wr_list_i] + CW'(1);
    end
  end

  // Memory array with registered read data
  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      mem_q[waddr] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[raddr];
    end
  end

endmodule

FILE: rtl/pda_stack.sv
// ----------------------------------------------------------------------------
// pda_stack: symbol stack storage
// One synchronous memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pda_stack #(
  parameter int unsigned STACK_DEPTH = 64,
  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic                        clk_i,
  input  pda_pkg::stack_cmd_t         cmd_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [pda_pkg::SYM_W-1:0]   wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [pda_pkg::SYM_W-1:0]   rdata_o
);
  import pda_pkg::*;

  logic [SYM_W-1:0] mem_q [STACK_DEPTH];
  logic [SYM_W-1:0] rdata_q;

  assign rdata_o = rdata_q;

  // Write pushed symbol, hold read data until the next read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/pushdown_automaton_recognizer.sv
// ----------------------------------------------------------------------------
// pushdown_automaton_recognizer: deterministic pushdown automaton
// Transition table load, symbol feed, word finish and table clear.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on in_valid_i/in_ready_o with an action code and its
//   fields; each accepted word yields exactly one result word on
//   out_valid_o/out_ready_i carrying status, run state and stack depth.
//   Add, clear and finish go from accept through the done state to the
//   output register. A feed on a non-empty list first scans it in the compare
//   state, from its head through the transition memory, one entry per cycle,
//   until a match or the end of the list. The stack top is read from
//   the stack memory in parallel with the first transition read.
//   One word is worked on at a time; the next is taken once the result has
//   moved to the output register, even while that result is still stalled.
//   A stalled output holds the result and blocks only the next completion.
//   Reset clears list counts, stack pointer, reject flag and run state (to
//   start state 0) with no clearing pass; both memories need none.
//   Configuration (start_state, final_mask) is written through cfg_we_i
//   while no word is in flight.
// ----------------------------------------------------------------------------
module pushdown_automaton_recognizer #(
  parameter int unsigned NUM_STATES      = 16,
  parameter int unsigned MAX_TRANSITIONS = 8,
  parameter int unsigned STACK_DEPTH     = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [pda_pkg::MASK_W-1:0]     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     action_i,
  input  logic [pda_pkg::STATE_W-1:0]    from_state_i,
  input  logic [pda_pkg::STATE_W-1:0]    to_state_i,
  input  logic [pda_pkg::SYM_W-1:0]      read_symbol_i,
  input  logic [pda_pkg::SYM_W-1:0]      push_symbol_i,
  input  logic [pda_pkg::SYM_W-1:0]      pop_symbol_i,
  input  logic [pda_pkg::SYM_W-1:0]      symbol_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [pda_pkg::STATUS_W-1:0]   status_o,
  output logic [pda_pkg::STATE_W-1:0]    current_state_o,
  output logic [pda_pkg::DEPTH_W-1:0]    stack_depth_o
);
  import pda_pkg::*;

  localparam int unsigned NUM_LISTS = (NUM_STATES < MAX_LISTS) ? NUM_STATES : MAX_LISTS;
  localparam int unsigned LW  = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int unsigned TW  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
  localparam int unsigned CW  = $clog2(MAX_TRANSITIONS + 1);
  localparam int unsigned AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_MASK  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DONE
  } state_e;

  state_e               state_q;
  status_e              res_status_q;
  logic [STATE_W-1:0]   start_q;
  logic [MASK_W-1:0]    mask_q;
  logic [STATE_W-1:0]   run_q;
  logic [SPW-1:0]       sp_q;
  logic                 reject_q;
  logic [CW-1:0]        k_q;
  logic [CW-1:0]        n_q;
  logic [SYM_W-1:0]     sym_q;
  logic                 out_valid_q;
  status_e              out_status_q;
  logic [STATE_W-1:0]   out_state_q;
  logic [SPW-1:0]       out_sp_q;

  action_e              act;
  logic                 acc;
  logic                 from_ok;
  logic                 run_ok;
  logic                 full;
  logic [LW-1:0]        run_list;
  logic [LW-1:0]        cnt_list;
  logic [CW-1:0]        cnt;
  logic [CW-1:0]        k_next;
  logic                 more;
  tstore_cmd_t          ts_cmd;
  trans_t               wr_trans;
  trans_t               trans;
  logic [TW-1:0]        rd_idx;
  stack_cmd_t           st_cmd;
  logic [SYM_W-1:0]     top;
  logic [SPW-1:0]       sp_dec;
  logic [SPW-1:0]       sp_base;
  logic [SPW-1:0]       sp_next;
  logic                 match;
  logic                 pop_try;
  logic                 pop_bad;
  logic                 has_push;
  logic                 ovf;
  logic                 out_load;

  // Decode the incoming word
  assign act      = action_e'(action_i);
  assign in_ready_o = (state_q == S_IDLE);
  assign acc      = in_valid_i && in_ready_o;
  assign from_ok  = (32'(from_state_i) < NUM_STATES) && (32'(to_state_i) < NUM_STATES);
  assign run_ok   = 32'(run_q) < NUM_STATES;
  assign run_list = run_q[LW-1:0];
  assign cnt_list = (act == ACT_ADD) ? from_state_i[LW-1:0] : run_list;
  assign full     = cnt >= CW'(MAX_TRANSITIONS);

  assign wr_trans.target = to_state_i;
  assign wr_trans.rd     = read_symbol_i;
  assign wr_trans.push   = push_symbol_i;
  assign wr_trans.pop    = pop_symbol_i;

  // Scan step: next list position and whether it is still in the list
  assign k_next = k_q + CW'(1);
  assign more   = k_next < n_q;

  // Evaluate the transition read back in the compare state
  assign match    = trans.rd == sym_q;
  assign pop_try  = (sp_q != '0) && (trans.pop != NONE_SYMBOL);
  assign pop_bad  = pop_try && (top != trans.pop);
  assign has_push = trans.push != NONE_SYMBOL;
  assign ovf      = has_push && !pop_try && (sp_q == SPW'(STACK_DEPTH));
  assign sp_dec   = sp_q - SPW'(1);
  assign sp_base  = pop_try ? sp_dec : sp_q;
  assign sp_next  = sp_base + SPW'(has_push);

  // Transition store commands
  always_comb begin
    ts_cmd.add   = acc && (act == ACT_ADD) && from_ok && !full;
    ts_cmd.clear = acc && (act == ACT_CLEAR);
    ts_cmd.rd_en = (acc && (act == ACT_FEED) && !reject_q && run_ok) ||
                   ((state_q == S_CMP) && !match && more);
    rd_idx       = (state_q == S_CMP) ? k_next[TW-1:0] : '0;
  end

  // Stack commands: fetch top on feed accept, push on a taken transition
  always_comb begin
    st_cmd.rd_en = acc && (act == ACT_FEED) && (sp_q != '0);
    st_cmd.wr_en = (state_q == S_CMP) && match && !pop_bad && !ovf && has_push;
  end

  pda_tstore #(
    .NUM_LISTS       (NUM_LISTS),
    .MAX_TRANSITIONS (MAX_TRANSITIONS)
  ) u_tstore (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (ts_cmd),
    .wr_list_i  (from_state_i[LW-1:0]),
    .wr_data_i  (wr_trans),
    .rd_list_i  (run_list),
    .rd_idx_i   (rd_idx),
    .rd_data_o  (trans),
    .cnt_list_i (cnt_list),
    .cnt_o      (cnt)
  );

  pda_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .cmd_i   (st_cmd),
    .waddr_i (sp_base[AW-1:0]),
    .wdata_i (trans.push),
    .raddr_i (sp_dec[AW-1:0]),
    .rdata_o (top)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      mask_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_START: start_q <= cfg_data_i[STATE_W-1:0];
        CFG_MASK:  mask_q  <= cfg_data_i;
        default:   mask_q  <= mask_q;
      endcase
    end
  end

  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer, run state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      res_status_q <= ST_OK;
      run_q        <= '0;
      sp_q         <= '0;
      reject_q     <= 1'b0;
      k_q          <= '0;
      n_q          <= '0;
      sym_q        <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_state_q  <= '0;
      out_sp_q     <= '0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            state_q <= S_DONE;
            unique case (act)
              ACT_ADD: begin
                if (!from_ok) begin
                  res_status_q <= ST_REFUSED;
                end else if (full) begin
                  res_status_q <= ST_FULL;
                end else begin
                  res_status_q <= ST_OK;
                end
              end
              ACT_FEED: begin
                if (reject_q) begin
                  res_status_q <= ST_REJECTED;
                end else if (!run_ok || (cnt == '0)) begin
                  res_status_q <= ST_NOMATCH;
                end else begin
                  k_q     <= '0;
                  n_q     <= cnt;
                  sym_q   <= symbol_i;
                  state_q <= S_CMP;
                end
              end
              ACT_FINISH: begin
                res_status_q <= (!reject_q && mask_q[run_q] && (sp_q == '0)) ?
                                ST_ACCEPTED : ST_REJECTED;
                run_q    <= start_q;
                sp_q     <= '0;
                reject_q <= 1'b0;
              end
              ACT_CLEAR: begin
                res_status_q <= ST_OK;
              end
              default: begin
                res_status_q <= ST_OK;
              end
            endcase
          end
        end
        S_CMP: begin
          if (match) begin
            state_q <= S_DONE;
            if (pop_bad) begin
              reject_q     <= 1'b1;
              res_status_q <= ST_REJECTED;
            end else if (ovf) begin
              reject_q     <= 1'b1;
              res_status_q <= ST_OVERFLOW;
            end else begin
              sp_q         <= sp_next;
              run_q        <= trans.target;
              res_status_q <= ST_OK;
            end
          end else if (more) begin
            k_q <= k_next;
          end else begin
            res_status_q <= ST_NOMATCH;
            state_q      <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_state_q  <= run_q;
            out_sp_q     <= sp_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign current_state_o = out_state_q;
  assign stack_depth_o   = DEPTH_W'(out_sp_q);

  // Stack pointer never passes the stack size
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  // Scan position stays inside the list length
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP) |-> (k_q < n_q) && (n_q <= CW'(MAX_TRANSITIONS)))
    else $error("scan position outside list");

  // Reject is set only by a transition evaluation
  a_reject_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(reject_q) |-> ($past(state_q) == S_CMP))
    else $error("reject set outside compare");

  // A completed word reaches the output register and frees the input
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == S_IDLE))
    else $error("result not delivered to output register");

endmodule
